// ===== rtl/mau_pkg.sv =====
`timescale 1ns / 1ps
package mau_pkg;

  localparam int unsigned ResW = 31;

  localparam logic [3:0] OP_REDUCE = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_NEG    = 4'd5;
  localparam logic [3:0] OP_POW    = 4'd6;
  localparam logic [3:0] OP_INV    = 4'd7;
  localparam logic [3:0] OP_EQUAL  = 4'd8;

  localparam logic [30:0] MOD_RESET = 31'd1000000007;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [30:0]        operand_a;
    logic [30:0]        operand_b;
    logic signed [63:0] exponent;
    logic signed [63:0] raw_value;
  } in_item_t;

  typedef struct packed {
    logic [30:0] result;
    logic        equal;
  } out_item_t;

endpackage

// ===== rtl/mau_modred.sv =====
`timescale 1ns / 1ps
// Sequential reduction x mod m, restoring, one bit per cycle, 64-bit x.
module mau_modred (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  input  logic [30:0] m,
  output logic        done,
  output logic [30:0] rem
);

  logic [31:0] rem_r, rem_nxt;
  logic [63:0] x_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [31:0] sh;

  always_comb begin
    sh = {rem_r[30:0], x_r[63]};
    if (sh >= {1'b0, m}) begin
      rem_nxt = sh - {1'b0, m};
    end else begin
      rem_nxt = sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 6'd0;
        rem_r <= '0;
        x_r   <= x;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        x_r   <= {x_r[62:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r[30:0];

endmodule

// ===== rtl/modular_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Modular ALU over the modulus in the cfg register (0 acts as 1). Pulse start
// while busy is low; out_valid strobes for one cycle with the result, which
// must be taken then. Every modular product or reduction goes through one
// shared 64-step bit-serial reducer. Pow takes up to about 126 products plus a
// closing inverse of up to 62 products.
module modular_arithmetic_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mau_pkg::in_item_t    in_item,
  output logic                 out_valid,
  output mau_pkg::out_item_t   out_item,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RA   = 8'b00000010,
    S_RB   = 8'b00000100,
    S_EXEC = 8'b00001000,
    S_PMUL = 8'b00010000,
    S_PSQR = 8'b00100000,
    S_POST = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  // phase of exponentiation: plain power, inverse power for div, then final mul
  typedef enum logic [2:0] {
    PH_POW = 3'b001,
    PH_INV = 3'b010,
    PH_FIN = 3'b100
  } phase_t;

  state_t      st_r;
  phase_t      ph_r;
  logic [30:0] mod_r, m;
  logic [3:0]  op_r;
  logic [30:0] a_r, b_r, acc_r, base_r, res_r;
  logic [63:0] e_r, raw_r;
  logic        neg_r, inv_after_r, eq_r, wait_r;
  logic        out_valid_r;
  logic        rd_start, rd_done;
  logic [63:0] rd_x;
  logic [30:0] rd_rem;
  logic [30:0] mul_a, mul_b;
  logic [61:0] prod;

  assign m = (mod_r == 31'd0) ? 31'd1 : mod_r;

  mau_modred u_red (
    .clk(clk), .rst_n(rst_n), .start(rd_start), .x(rd_x), .m(m),
    .done(rd_done), .rem(rd_rem)
  );

  logic [63:0] mag;
  assign mag = (raw_r[63]) ? (64'd0 - raw_r) : raw_r;

  // Start pow setup: acc=1 mod m, base given, exponent e
  logic [30:0] one_m;
  assign one_m = (m == 31'd1) ? 31'd0 : 31'd1;

  logic [31:0] sum;
  logic [31:0] dif;
  assign sum = {1'b0, a_r} + {1'b0, b_r};
  assign dif = {1'b0, a_r} + {1'b0, m} - {1'b0, b_r};

  logic [30:0] msub2;
  assign msub2 = m - 31'd2;

  // one shared multiplier feeds the reducer
  always_comb begin
    mul_a = base_r;
    mul_b = base_r;
    case (st_r)
      S_PMUL: begin
        mul_a = acc_r;
        mul_b = base_r;
      end
      S_POST: begin
        mul_a = a_r;
        mul_b = acc_r;
      end
      default: begin
        mul_a = base_r;
        mul_b = base_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    rd_x = '0;
    case (st_r)
      S_RA:    rd_x = (op_r == mau_pkg::OP_REDUCE) ? mag : {33'd0, a_r};
      S_RB:    rd_x = {33'd0, b_r};
      S_PMUL:  rd_x = {2'b00, prod};
      S_PSQR:  rd_x = {2'b00, prod};
      S_POST:  rd_x = {2'b00, prod};
      default: rd_x = '0;
    endcase
  end

  // the reducer must not be launched on a zero-exponent or even-bit step
  logic pmul_skip;
  assign pmul_skip = (st_r == S_PMUL) && (e_r == 64'd0 || !e_r[0]);

  assign rd_start = !wait_r && !pmul_skip && (st_r == S_RA || st_r == S_RB
                    || st_r == S_PMUL || st_r == S_PSQR || st_r == S_POST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ph_r        <= PH_POW;
      mod_r       <= mau_pkg::MOD_RESET;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        mod_r <= cfg_wdata;
      end
      if (rd_start) begin
        wait_r <= 1'b1;
      end
      case (st_r)
        S_IDLE: begin
          if (start) begin
            op_r  <= in_item.opcode;
            a_r   <= in_item.operand_a;
            b_r   <= in_item.operand_b;
            raw_r <= in_item.raw_value;
            if (in_item.exponent[63]) begin
              e_r <= (in_item.exponent == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}}
                     : (64'd0 - in_item.exponent);
            end else begin
              e_r <= in_item.exponent;
            end
            neg_r <= in_item.exponent[63];
            eq_r  <= 1'b0;
            res_r <= '0;
            st_r  <= S_RA;
          end
        end
        S_RA: begin
          if (rd_done) begin
            wait_r <= 1'b0;
            if (op_r == mau_pkg::OP_REDUCE) begin
              res_r <= (raw_r[63] && rd_rem != 31'd0) ? m - rd_rem : rd_rem;
              st_r  <= S_DONE;
            end else begin
              a_r  <= rd_rem;
              st_r <= S_RB;
            end
          end
        end
        S_RB: begin
          if (rd_done) begin
            wait_r <= 1'b0;
            b_r    <= rd_rem;
            st_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_r        <= S_DONE;
          inv_after_r <= 1'b0;
          acc_r       <= one_m;
          ph_r        <= PH_POW;
          case (op_r)
            mau_pkg::OP_ADD:
              res_r <= (sum >= {1'b0, m}) ? sum[30:0] - m : sum[30:0];
            mau_pkg::OP_SUB:
              res_r <= (dif >= {1'b0, m}) ? dif[30:0] - m : dif[30:0];
            mau_pkg::OP_NEG:
              res_r <= (a_r == 31'd0) ? 31'd0 : m - a_r;
            mau_pkg::OP_EQUAL:
              eq_r <= (a_r == b_r);
            mau_pkg::OP_MUL: begin
              acc_r <= b_r;
              ph_r  <= PH_FIN;
              st_r  <= S_POST;
            end
            mau_pkg::OP_DIV: begin
              // a * b^(m-2), zero when b is zero or m < 2
              if (b_r == 31'd0 || m < 31'd2) begin
                res_r <= '0;
              end else begin
                base_r <= b_r;
                e_r    <= {33'd0, msub2};
                ph_r   <= PH_INV;
                st_r   <= S_PMUL;
              end
            end
            mau_pkg::OP_POW: begin
              base_r      <= a_r;
              inv_after_r <= neg_r;
              st_r        <= S_PMUL;
            end
            mau_pkg::OP_INV: begin
              if (a_r == 31'd0 || m < 31'd2) begin
                res_r <= '0;
              end else begin
                base_r <= a_r;
                e_r    <= {33'd0, msub2};
                st_r   <= S_PMUL;
              end
            end
            default: res_r <= '0;
          endcase
        end
        S_PMUL: begin
          // multiply acc by base when the low exponent bit is set; a zero exponent ends the power
          if (e_r == 64'd0) begin
            wait_r <= 1'b0;
            if (ph_r == PH_INV) begin
              ph_r <= PH_FIN;
              st_r <= S_POST;
            end else if (inv_after_r) begin
              inv_after_r <= 1'b0;
              if (acc_r == 31'd0 || m < 31'd2) begin
                res_r <= '0;
                st_r  <= S_DONE;
              end else begin
                base_r <= acc_r;
                acc_r  <= one_m;
                e_r    <= {33'd0, msub2};
              end
            end else begin
              res_r <= acc_r;
              st_r  <= S_DONE;
            end
          end else if (!e_r[0]) begin
            wait_r <= 1'b0;
            st_r   <= S_PSQR;
          end else if (rd_done) begin
            wait_r <= 1'b0;
            acc_r  <= rd_rem;
            st_r   <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (rd_done) begin
            wait_r <= 1'b0;
            base_r <= rd_rem;
            e_r    <= {1'b0, e_r[63:1]};
            st_r   <= S_PMUL;
          end
        end
        S_POST: begin
          if (rd_done) begin
            wait_r <= 1'b0;
            res_r  <= rd_rem;
            st_r   <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          st_r        <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (st_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_item.result = res_r;
  assign out_item.equal  = eq_r;

`ifndef NO_ASSERTIONS
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy while strobing result");
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.result < m)) else $error("result out of range");
  a_eq_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r != mau_pkg::OP_EQUAL) |-> !out_item.equal)
    else $error("equal flag on wrong opcode");
`endif

endmodule
